>>> design/tevq_pkg.sv
package tevq_pkg;

  localparam int QUEUE_DEPTH = 256;
  localparam int SOURCE_BITS = 16;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = IDX_W + 1;
  localparam int SEQ_W       = 48;

  localparam logic [2:0] ST_SCHEDULED = 3'd0;
  localparam logic [2:0] ST_PAST_END  = 3'd1;
  localparam logic [2:0] ST_EARLY     = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_POPPED    = 3'd4;
  localparam logic [2:0] ST_EMPTY     = 3'd5;

  localparam logic CMD_SCHEDULE = 1'b0;
  localparam logic CMD_POP      = 1'b1;

  typedef struct packed {
    logic [63:0]            etime;
    logic [SEQ_W-1:0]       seq;
    logic [SOURCE_BITS-1:0] src;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP_RD,
    S_DN_RD,
    S_DN_CMP,
    S_UP_RD,
    S_UP_CMP
  } state_t;

  // heap order: earlier time first, then earlier insertion
  function automatic logic key_less(entry_t a, entry_t b);
    return {a.etime, a.seq} < {b.etime, b.seq};
  endfunction

endpackage

>>> design/timed_event_queue_top.sv
// Timed event queue: a min-heap of events ordered by time, ties leaving in
// insertion order.
// Command channel: an item (command, event_time, source_id) is taken at a
// clock edge with start high and busy low. Schedule = command 0, pop = 1.
// Result channel: done is high for exactly one cycle with status,
// popped_time, popped_source, now_time and processed_total. The receiver
// cannot stall; the result must be taken in that cycle.
// The user writes end_time (end_time_we / end_time_data) only while idle;
// the block itself does not enforce this. Rejected schedules and pops
// of an empty queue report in the cycle after the item is taken. A
// schedule sifts up the heap one level per parent read and compare/write
// step pair. A pop reads root and last entry, then sifts down one level
// per read and compare/write step pair, both children read together on
// the dual-read heap memory.
// One item is worked on at a time; busy is high until its result is out.
// Reset (rst, synchronous) empties the queue and clears the current time,
// pop count and end_time. Heap memory needs no clearing: only entries
// below the entry count are used.
module timed_event_queue_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic                             command,
  input  logic [63:0]                      event_time,
  input  logic [15:0]                      source_id,
  input  logic                             end_time_we,
  input  logic [63:0]                      end_time_data,
  output logic                             done,
  output logic [2:0]                       status,
  output logic [63:0]                      popped_time,
  output logic [15:0]                      popped_source,
  output logic [63:0]                      now_time,
  output logic [47:0]                      processed_total
);
  import tevq_pkg::*;

  state_t state, state_next;

  logic [CNT_W-1:0]  count, count_next;
  logic [IDX_W-1:0]  hole, hole_next;
  entry_t            key, key_next;
  logic [SEQ_W-1:0]  seq_ctr, seq_ctr_next;
  logic [63:0]       cur_time, cur_time_next;
  logic [47:0]       proc_cnt, proc_cnt_next;
  logic [63:0]       end_time;
  logic              done_next;
  logic [2:0]        status_next;
  logic [63:0]       popped_time_next;
  logic [15:0]       popped_source_next;

  logic              we;
  logic [IDX_W-1:0]  wr_addr, rd_a_addr, rd_b_addr;
  entry_t            wr_data, rd_a_data, rd_b_data;

  tevq_ram #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_heap (
    .clk       (clk),
    .we        (we),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_a_addr (rd_a_addr),
    .rd_a_data (rd_a_data),
    .rd_b_addr (rd_b_addr),
    .rd_b_data (rd_b_data)
  );

  logic              accept, is_pop, is_empty, is_early, is_past, is_full, immediate;
  logic [IDX_W-1:0]  parent;
  logic [IDX_W+1:0]  c1, c2;
  logic              c2_valid, dn_leaf, dn_move, up_move, up_root, pop_last;
  entry_t            child;
  logic [IDX_W-1:0]  child_idx;

  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;
  assign is_pop    = (command == CMD_POP);
  assign is_empty  = (count == '0);
  assign is_early  = (event_time < cur_time);
  assign is_past   = (end_time != 64'd0) && (event_time > end_time);
  assign is_full   = (count == CNT_W'(QUEUE_DEPTH));
  assign immediate = is_pop ? is_empty : (is_early || is_past || is_full);

  assign parent   = (hole - IDX_W'(1)) >> 1;
  assign up_root  = (hole == '0);
  assign up_move  = key_less(key, rd_a_data);
  assign c1       = {1'b0, hole, 1'b1};
  assign c2       = c1 + (IDX_W+2)'(1);
  assign dn_leaf  = (c1 >= (IDX_W+2)'(count));
  assign c2_valid = (c2 < (IDX_W+2)'(count));
  assign pop_last = (count == CNT_W'(1));

  always_comb begin
    if (c2_valid && key_less(rd_b_data, rd_a_data)) begin
      child     = rd_b_data;
      child_idx = c2[IDX_W-1:0];
    end else begin
      child     = rd_a_data;
      child_idx = c1[IDX_W-1:0];
    end
  end
  assign dn_move = key_less(child, key);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && !immediate) begin
          state_next = is_pop ? S_POP_RD : S_UP_RD;
        end
      end
      S_POP_RD: state_next = pop_last ? S_IDLE : S_DN_RD;
      S_DN_RD:  state_next = dn_leaf ? S_IDLE : S_DN_CMP;
      S_DN_CMP: state_next = dn_move ? S_DN_RD : S_IDLE;
      S_UP_RD:  state_next = up_root ? S_IDLE : S_UP_CMP;
      S_UP_CMP: state_next = up_move ? S_UP_RD : S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    count_next         = count;
    hole_next          = hole;
    key_next           = key;
    seq_ctr_next       = seq_ctr;
    cur_time_next      = cur_time;
    proc_cnt_next      = proc_cnt;
    done_next          = 1'b0;
    status_next        = status;
    popped_time_next   = popped_time;
    popped_source_next = popped_source;
    we                 = 1'b0;
    wr_addr            = hole;
    wr_data            = key;
    rd_a_addr          = '0;
    rd_b_addr          = '0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          popped_time_next   = 64'd0;
          popped_source_next = 16'd0;
          if (is_pop) begin
            if (is_empty) begin
              status_next = ST_EMPTY;
              done_next   = 1'b1;
            end else begin
              rd_a_addr = '0;
              rd_b_addr = IDX_W'(count - CNT_W'(1));
            end
          end else if (is_early) begin
            status_next = ST_EARLY;
            done_next   = 1'b1;
          end else if (is_past) begin
            status_next = ST_PAST_END;
            done_next   = 1'b1;
          end else if (is_full) begin
            status_next = ST_FULL;
            done_next   = 1'b1;
          end else begin
            key_next     = '{etime: event_time, seq: seq_ctr,
                             src: source_id[SOURCE_BITS-1:0]};
            seq_ctr_next = seq_ctr + SEQ_W'(1);
            hole_next    = count[IDX_W-1:0];
            count_next   = count + CNT_W'(1);
            status_next  = ST_SCHEDULED;
          end
        end
      end
      S_POP_RD: begin
        status_next        = ST_POPPED;
        popped_time_next   = rd_a_data.etime;
        popped_source_next = 16'(rd_a_data.src);
        cur_time_next      = rd_a_data.etime;
        proc_cnt_next      = proc_cnt + 48'd1;
        count_next         = count - CNT_W'(1);
        key_next           = rd_b_data;
        hole_next          = '0;
        done_next          = pop_last;
      end
      S_DN_RD: begin
        rd_a_addr = c1[IDX_W-1:0];
        rd_b_addr = c2[IDX_W-1:0];
        if (dn_leaf) begin
          we        = 1'b1;
          done_next = 1'b1;
        end
      end
      S_DN_CMP: begin
        we = 1'b1;
        if (dn_move) begin
          wr_data   = child;
          hole_next = child_idx;
        end else begin
          done_next = 1'b1;
        end
      end
      S_UP_RD: begin
        rd_a_addr = parent;
        if (up_root) begin
          we        = 1'b1;
          done_next = 1'b1;
        end
      end
      S_UP_CMP: begin
        we = 1'b1;
        if (up_move) begin
          wr_data   = rd_a_data;
          hole_next = parent;
        end else begin
          done_next = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      seq_ctr  <= '0;
      cur_time <= '0;
      proc_cnt <= '0;
      end_time <= '0;
      done     <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      seq_ctr  <= seq_ctr_next;
      cur_time <= cur_time_next;
      proc_cnt <= proc_cnt_next;
      done     <= done_next;
      if (end_time_we) begin
        end_time <= end_time_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    hole          <= hole_next;
    key           <= key_next;
    status        <= status_next;
    popped_time   <= popped_time_next;
    popped_source <= popped_source_next;
  end

  assign now_time        = cur_time;
  assign processed_total = proc_cnt;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("entry count above depth");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> state == S_IDLE)
    else $error("result strobe while busy");

  a_fast_result: assert property (@(posedge clk) disable iff (rst)
    (accept && immediate) |=> done)
    else $error("immediate result missing");

  a_write_in_heap: assert property (@(posedge clk) disable iff (rst)
    we |-> CNT_W'(wr_addr) < count)
    else $error("heap write beyond entry count");
`endif

endmodule

>>> design/tevq_ram.sv
module tevq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_a_addr,
  output logic [WIDTH-1:0]         rd_a_data,
  input  logic [$clog2(DEPTH)-1:0] rd_b_addr,
  output logic [WIDTH-1:0]         rd_b_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_a_data <= mem[rd_a_addr];
    rd_b_data <= mem[rd_b_addr];
  end

endmodule
